[rtl/core/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the syntax-class lexer
// Class codes, column defaults and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    localparam int unsigned COLUMN_BITS_DEF = 16;
    localparam int unsigned TAB_BITS        = 5;
    localparam int unsigned PHASE_BITS      = 4;
    localparam int unsigned COL_OUT_BITS    = 16;

    localparam logic [TAB_BITS-1:0] TAB_SIZE_RST = 5'd4;
    localparam logic [TAB_BITS-1:0] TAB_SIZE_MIN = 5'd1;
    localparam logic [TAB_BITS-1:0] TAB_SIZE_MAX = 5'd16;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        LEX_DEFAULT  = 3'd0,
        LEX_COMMENT  = 3'd1,
        LEX_STRING   = 3'd2,
        LEX_NUMBER   = 3'd3,
        LEX_OPERATOR = 3'd4,
        LEX_PREPROC  = 3'd5
    } t_lex_state;

    // one beat handed from the input stage to the step logic
    typedef struct packed {
        logic       step;
        logic       line_start;
        logic [7:0] text_byte;
        logic [7:0] next_byte;
    } t_step;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

endpackage

`default_nettype wire

[rtl/core/csl_ifs.sv]
// ----------------------------------------------------------------------------
// csl_ifs: stream interfaces of the syntax-class lexer
// Input byte channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface csl_in_if;
    logic       valid;
    logic       ready;
    logic       line_start;
    logic [7:0] text_byte;
    logic [7:0] next_byte;

    modport source (output valid, line_start, text_byte, next_byte, input ready);
    modport sink   (input valid, line_start, text_byte, next_byte, output ready);
endinterface

interface csl_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  color_class;
    logic        draw_glyph;
    logic [15:0] start_column;
    logic [4:0]  advance;

    modport source (output valid, color_class, draw_glyph, start_column, advance,
                    input ready);
    modport sink   (input valid, color_class, draw_glyph, start_column, advance,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/code_syntax_class_lexer.sv]
// ----------------------------------------------------------------------------
// code_syntax_class_lexer: per-byte syntax class and column of source text
// Usage:
//   i_in carries one text byte per beat with its lookahead byte and a
//   line-start mark that clears lexer state, column and tab phase.
//   o_out returns one beat per input beat: class, glyph flag, start column
//   and advance in columns. Order is kept, one result per byte.
//   i_cfg_we/i_cfg_wdata write the tab size; write only while idle.
// Timing:
//   Input register then result register: an accepted beat moves on when
//   the result register is empty or taken. Throughput is one byte per
//   cycle while o_out is not stalled; the lexer state and column update in
//   the same cycle the byte moves to the result register.
// Stall:
//   While o_out is stalled the result holds; the input register takes one
//   more beat, then i_in.ready drops until the result is taken.
// Reset:
//   Synchronous, active low: lexer state and column cleared, tab size 4,
//   both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module code_syntax_class_lexer #(
    parameter int unsigned COLUMN_BITS = csl_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    csl_in_if.sink                             i_in,
    csl_out_if.source                          o_out,
    input  wire logic                          i_cfg_we,
    input  wire logic [csl_pkg::TAB_BITS-1:0]  i_cfg_wdata
);

    logic                          r_in_valid;
    logic                          r_in_ls;
    logic [7:0]                    r_in_c;
    logic [7:0]                    r_in_nx;
    logic                          r_out_valid;
    logic [csl_pkg::TAB_BITS-1:0]  r_tab_size;

    logic                          fwd;
    csl_pkg::t_step                step;
    logic [2:0]                    cls;
    logic                          glyph;
    logic [15:0]                   scol;
    logic [csl_pkg::TAB_BITS-1:0]  adv;

    assign fwd        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fwd;

    always_comb begin
        step.step       = fwd;
        step.line_start = r_in_ls;
        step.text_byte  = r_in_c;
        step.next_byte  = r_in_nx;
    end

    csl_lex u_lex (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .o_color_class (cls)
    );

    csl_col #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_col (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_tab_size     (r_tab_size),
        .o_draw_glyph   (glyph),
        .o_start_column (scol),
        .o_advance      (adv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tab_size  <= csl_pkg::TAB_SIZE_RST;
        end else begin
            if (i_cfg_we) r_tab_size <= i_cfg_wdata;
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (fwd) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ls <= i_in.line_start;
            r_in_c  <= i_in.text_byte;
            r_in_nx <= i_in.next_byte;
        end
        if (fwd) begin
            o_out.color_class  <= cls;
            o_out.draw_glyph   <= glyph;
            o_out.start_column <= scol;
            o_out.advance      <= adv;
        end
    end

    assign o_out.valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/core/csl_lex.sv]
// ----------------------------------------------------------------------------
// csl_lex: lexer state and class decision
// Holds the lexer state and flags, gives the class of the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_lex (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire csl_pkg::t_step     i_step,
    output logic [2:0]              o_color_class
);

    csl_pkg::t_lex_state r_state, n_state;
    logic                r_bc, n_bc;
    logic                r_idf, n_idf;
    logic                r_chr, n_chr;
    logic                r_so, n_so;
    logic [15:0]         r_prev, n_prev;

    csl_pkg::t_lex_state st;
    logic                bc, idf, chr, so;
    logic [7:0]          p1, p2, c, nx;
    logic                alnum;

    always_comb begin
        c     = i_step.text_byte;
        nx    = i_step.next_byte;
        st    = i_step.line_start ? csl_pkg::LEX_DEFAULT : r_state;
        bc    = i_step.line_start ? 1'b0 : r_bc;
        idf   = i_step.line_start ? 1'b0 : r_idf;
        chr   = i_step.line_start ? 1'b0 : r_chr;
        so    = i_step.line_start ? 1'b0 : r_so;
        p1    = i_step.line_start ? 8'h00 : r_prev[7:0];
        p2    = i_step.line_start ? 8'h00 : r_prev[15:8];
        alnum = csl_pkg::is_letter(c) || csl_pkg::is_digit(c);

        // close the running token
        case (st)
            csl_pkg::LEX_OPERATOR: begin
                st = csl_pkg::LEX_DEFAULT;
            end
            csl_pkg::LEX_COMMENT: begin
                if (p2 == csl_pkg::CH_STAR && p1 == csl_pkg::CH_SLASH && bc) begin
                    st = csl_pkg::LEX_DEFAULT;
                    bc = 1'b0;
                end
            end
            csl_pkg::LEX_NUMBER: begin
                if (!alnum) st = csl_pkg::LEX_DEFAULT;
            end
            csl_pkg::LEX_STRING: begin
                if (!so && p2 != csl_pkg::CH_BSLASH) begin
                    if (!chr && p1 == csl_pkg::CH_DQUOTE) st = csl_pkg::LEX_DEFAULT;
                    else if (chr && p1 == csl_pkg::CH_SQUOTE) st = csl_pkg::LEX_DEFAULT;
                end
                so = 1'b0;
            end
            default: ;
        endcase

        // open a new token
        if (st == csl_pkg::LEX_DEFAULT) begin
            if (c == csl_pkg::CH_HASH) begin
                st = csl_pkg::LEX_PREPROC;
            end else if (c == csl_pkg::CH_SLASH && nx == csl_pkg::CH_SLASH) begin
                st = csl_pkg::LEX_COMMENT;
            end else if (c == csl_pkg::CH_SLASH && nx == csl_pkg::CH_STAR) begin
                st = csl_pkg::LEX_COMMENT;
                bc = 1'b1;
            end else if (c == csl_pkg::CH_DQUOTE) begin
                st  = csl_pkg::LEX_STRING;
                chr = 1'b0;
                so  = 1'b1;
            end else if (c == csl_pkg::CH_SQUOTE) begin
                st  = csl_pkg::LEX_STRING;
                chr = 1'b1;
                so  = 1'b1;
            end else if (csl_pkg::is_digit(c) && !idf) begin
                st = csl_pkg::LEX_NUMBER;
            end else if (!alnum) begin
                st  = csl_pkg::LEX_OPERATOR;
                idf = 1'b0;
            end else begin
                idf = 1'b1;
            end
        end

        n_state = st;
        n_bc    = bc;
        n_idf   = idf;
        n_chr   = chr;
        n_so    = so;
        n_prev  = {p1, c};
        o_color_class = st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csl_pkg::LEX_DEFAULT;
            r_bc    <= 1'b0;
            r_idf   <= 1'b0;
            r_chr   <= 1'b0;
            r_so    <= 1'b0;
            r_prev  <= 16'h0000;
        end else if (i_step.step) begin
            r_state <= n_state;
            r_bc    <= n_bc;
            r_idf   <= n_idf;
            r_chr   <= n_chr;
            r_so    <= n_so;
            r_prev  <= n_prev;
        end
    end

endmodule

`default_nettype wire

[rtl/core/csl_col.sv]
// ----------------------------------------------------------------------------
// csl_col: column tracker with tab expansion
// Tab phase counter and saturating column counter.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_col #(
    parameter int unsigned COLUMN_BITS = csl_pkg::COLUMN_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire csl_pkg::t_step                    i_step,
    input  wire logic [csl_pkg::TAB_BITS-1:0]      i_tab_size,
    output logic                                   o_draw_glyph,
    output logic [csl_pkg::COL_OUT_BITS-1:0]       o_start_column,
    output logic [csl_pkg::TAB_BITS-1:0]           o_advance
);

    logic [COLUMN_BITS-1:0]          r_col, n_col;
    logic [csl_pkg::PHASE_BITS-1:0]  r_phase, n_phase;

    logic [COLUMN_BITS-1:0]          col;
    logic [COLUMN_BITS:0]            sum;
    logic [csl_pkg::TAB_BITS-1:0]    ts, ph, ph_inc;
    logic                            tab;

    always_comb begin
        tab = (i_step.text_byte == csl_pkg::CH_TAB);
        col = i_step.line_start ? '0 : r_col;

        if (i_tab_size < csl_pkg::TAB_SIZE_MIN)      ts = csl_pkg::TAB_SIZE_MIN;
        else if (i_tab_size > csl_pkg::TAB_SIZE_MAX) ts = csl_pkg::TAB_SIZE_MAX;
        else                                         ts = i_tab_size;

        ph = i_step.line_start ? '0 : {1'b0, r_phase};
        if (ph >= ts) ph = '0;

        ph_inc = ph + 5'd1;
        if (tab) begin
            o_advance = ts - ph;
            n_phase   = '0;
        end else begin
            o_advance = 5'd1;
            n_phase   = (ph_inc >= ts) ? '0 : ph_inc[csl_pkg::PHASE_BITS-1:0];
        end

        sum   = {1'b0, col} + (COLUMN_BITS+1)'(o_advance);
        n_col = sum[COLUMN_BITS] ? '1 : sum[COLUMN_BITS-1:0];

        o_draw_glyph   = !tab;
        o_start_column = csl_pkg::COL_OUT_BITS'(col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_phase <= '0;
        end else if (i_step.step) begin
            r_col   <= n_col;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

[tb/code_syntax_class_lexer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// code_syntax_class_lexer_tb: self-checking bench for the syntax-class lexer
// Drives text bytes with lookahead and line-start marks through the input
// channel. Checks class, glyph flag, start column and advance of each result
// against an in-bench classifier or fixed table values. Stimulus order:
// a directed table, a tab-size change in mid-line, a column-saturation line,
// then random C-like lines under several tab sizes. Both sides stall at random.
// ----------------------------------------------------------------------------

module code_syntax_class_lexer_tb;

    import csl_pkg::*;

    typedef struct packed {
        t_lex_state  cls;
        logic        glyph;
        logic [15:0] col;
        logic [4:0]  adv;
    } lex_out_t;

    typedef struct {
        logic       ls;
        logic [7:0] c;
        logic [7:0] nx;
        logic       fixed;
        lex_out_t   want;
    } dir_row_t;

    localparam lex_out_t NO_WANT = '0;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [TAB_BITS-1:0] i_cfg_wdata;

    csl_in_if  in_bus ();
    csl_out_if res_bus ();

    code_syntax_class_lexer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (res_bus),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // classifier state
    t_lex_state  lx_state;
    logic        in_block;
    logic        in_ident;
    logic        in_char;
    logic        str_fresh;
    logic [15:0] last_two;
    logic [15:0] col_cnt;
    logic [3:0]  phase;
    logic [4:0]  tab_cfg;

    lex_out_t   pending_lex_q[$];
    logic [7:0] text_q[$];
    string      op_chars = "+-*/=<>;(){}[]!&|%^~?:.,";

    int  err_count;
    int  bytes_sent;
    int  lines_sent;
    int  results_checked;
    int  tab_writes;
    logic no_gaps;

    dir_row_t dir_rows [29] = '{
        '{1'b0, CH_HASH,   "i",       1'b1, '{LEX_PREPROC,  1'b1, 16'd0, 5'd1}},
        '{1'b1, CH_TAB,    "a",       1'b1, '{LEX_OPERATOR, 1'b0, 16'd0, 5'd4}},
        '{1'b0, 8'hFF,     8'h00,     1'b1, '{LEX_OPERATOR, 1'b1, 16'd4, 5'd1}},
        '{1'b1, 8'h00,     8'hFF,     1'b1, '{LEX_OPERATOR, 1'b1, 16'd0, 5'd1}},
        '{1'b1, CH_SLASH,  CH_SLASH,  1'b0, NO_WANT},
        '{1'b0, CH_SLASH,  "x",       1'b0, NO_WANT},
        '{1'b0, "x",       8'h0A,     1'b0, NO_WANT},
        '{1'b1, CH_SLASH,  CH_STAR,   1'b0, NO_WANT},
        '{1'b0, CH_STAR,   CH_SLASH,  1'b0, NO_WANT},
        '{1'b0, CH_SLASH,  "a",       1'b0, NO_WANT},
        '{1'b0, "a",       CH_DQUOTE, 1'b0, NO_WANT},
        '{1'b1, CH_DQUOTE, CH_BSLASH, 1'b0, NO_WANT},
        '{1'b0, CH_BSLASH, CH_DQUOTE, 1'b0, NO_WANT},
        '{1'b0, CH_DQUOTE, CH_DQUOTE, 1'b0, NO_WANT},
        '{1'b0, CH_DQUOTE, "x",       1'b0, NO_WANT},
        '{1'b0, "x",       " ",       1'b0, NO_WANT},
        '{1'b1, CH_SQUOTE, CH_BSLASH, 1'b0, NO_WANT},
        '{1'b0, CH_BSLASH, CH_SQUOTE, 1'b0, NO_WANT},
        '{1'b0, CH_SQUOTE, CH_SQUOTE, 1'b0, NO_WANT},
        '{1'b0, CH_SQUOTE, ";",       1'b0, NO_WANT},
        '{1'b0, ";",       8'h00,     1'b0, NO_WANT},
        '{1'b1, "1",       "2",       1'b0, NO_WANT},
        '{1'b0, "2",       "x",       1'b0, NO_WANT},
        '{1'b0, "x",       " ",       1'b0, NO_WANT},
        '{1'b0, " ",       "v",       1'b0, NO_WANT},
        '{1'b0, "v",       "9",       1'b0, NO_WANT},
        '{1'b0, "9",       CH_TAB,    1'b0, NO_WANT},
        '{1'b0, CH_TAB,    "+",       1'b0, NO_WANT},
        '{1'b0, "_",       8'h7F,     1'b0, NO_WANT}
    };

    function automatic logic word_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic dec_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_line();
        lx_state  = LEX_DEFAULT;
        in_block  = 1'b0;
        in_ident  = 1'b0;
        in_char   = 1'b0;
        str_fresh = 1'b0;
        last_two  = '0;
        col_cnt   = '0;
        phase     = '0;
    endfunction

    function automatic lex_out_t classify_byte(input logic ls, input logic [7:0] c,
                                               input logic [7:0] nx);
        logic [7:0]  p1;
        logic [7:0]  p2;
        logic [4:0]  ts;
        logic [4:0]  adv;
        logic [4:0]  ph_next;
        logic [16:0] sum;
        lex_out_t    r;
        if (ls)
            clear_line();
        p1 = last_two[7:0];
        p2 = last_two[15:8];
        last_two = {p1, c};

        case (lx_state)
            LEX_OPERATOR: lx_state = LEX_DEFAULT;
            LEX_COMMENT: begin
                if (p2 == CH_STAR && p1 == CH_SLASH && in_block) begin
                    lx_state = LEX_DEFAULT;
                    in_block = 1'b0;
                end
            end
            LEX_NUMBER: begin
                if (!word_letter(c) && !dec_digit(c))
                    lx_state = LEX_DEFAULT;
            end
            LEX_STRING: begin
                if (!str_fresh && p2 != CH_BSLASH) begin
                    if (!in_char && p1 == CH_DQUOTE)
                        lx_state = LEX_DEFAULT;
                    else if (in_char && p1 == CH_SQUOTE)
                        lx_state = LEX_DEFAULT;
                end
                str_fresh = 1'b0;
            end
            default: ;
        endcase

        if (lx_state == LEX_DEFAULT) begin
            if (c == CH_HASH) begin
                lx_state = LEX_PREPROC;
            end else if (c == CH_SLASH && nx == CH_SLASH) begin
                lx_state = LEX_COMMENT;
            end else if (c == CH_SLASH && nx == CH_STAR) begin
                lx_state = LEX_COMMENT;
                in_block = 1'b1;
            end else if (c == CH_DQUOTE) begin
                lx_state  = LEX_STRING;
                in_char   = 1'b0;
                str_fresh = 1'b1;
            end else if (c == CH_SQUOTE) begin
                lx_state  = LEX_STRING;
                in_char   = 1'b1;
                str_fresh = 1'b1;
            end else if (dec_digit(c) && !in_ident) begin
                lx_state = LEX_NUMBER;
            end else if (!word_letter(c) && !dec_digit(c)) begin
                lx_state = LEX_OPERATOR;
                in_ident = 1'b0;
            end else begin
                in_ident = 1'b1;
            end
        end

        ts = tab_cfg;
        if (ts == 5'd0)
            ts = 5'd1;
        if (ts > 5'd16)
            ts = 5'd16;
        if ({1'b0, phase} >= ts)
            phase = '0;

        if (c == CH_TAB) begin
            adv   = ts - {1'b0, phase};
            phase = '0;
        end else begin
            adv     = 5'd1;
            ph_next = {1'b0, phase} + 5'd1;
            phase   = (ph_next >= ts) ? 4'd0 : ph_next[3:0];
        end

        r.cls   = lx_state;
        r.glyph = (c != CH_TAB);
        r.col   = col_cnt;
        r.adv   = adv;

        sum = {1'b0, col_cnt} + {12'd0, adv};
        col_cnt = sum[16] ? 16'hFFFF : sum[15:0];
        return r;
    endfunction

    function automatic logic gap_now();
        return !no_gaps && ($urandom_range(99) < 7);
    endfunction

    function automatic logic [7:0] any_letter();
        int k;
        k = $urandom_range(52);
        if (k < 26)
            return 8'("A" + k);
        else if (k < 52)
            return 8'("a" + k - 26);
        return "_";
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    function automatic void add_token();
        int n;
        logic [7:0] quote;
        case ($urandom_range(15))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) text_q.push_back(any_letter());
            end
            3, 4: begin
                n = $urandom_range(1, 4);
                repeat (n) text_q.push_back(8'("0" + $urandom_range(9)));
                if ($urandom_range(3) == 0)
                    text_q.push_back(any_letter());
            end
            5, 6: begin
                quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                text_q.push_back(quote);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(5))
                        0: begin
                            text_q.push_back(CH_BSLASH);
                            text_q.push_back(quote);
                        end
                        1: text_q.push_back(CH_BSLASH);
                        default: text_q.push_back(printable());
                    endcase
                end
                if ($urandom_range(7) != 0)
                    text_q.push_back(quote);
            end
            7: begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_SLASH);
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back(printable());
            end
            8: begin
                text_q.push_back(CH_SLASH);
                text_q.push_back(CH_STAR);
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back($urandom_range(3) == 0 ? CH_STAR : printable());
                if ($urandom_range(7) != 0) begin
                    text_q.push_back(CH_STAR);
                    text_q.push_back(CH_SLASH);
                end
            end
            9: begin
                text_q.push_back(CH_HASH);
                n = $urandom_range(0, 6);
                repeat (n) text_q.push_back(any_letter());
            end
            10, 11: text_q.push_back(8'(op_chars[$urandom_range(op_chars.len() - 1)]));
            12: text_q.push_back(" ");
            13: text_q.push_back(CH_TAB);
            14: text_q.push_back(8'($urandom_range(255)));
            default: begin
                case ($urandom_range(2))
                    0: text_q.push_back(CH_SLASH);
                    1: text_q.push_back(CH_STAR);
                    default: text_q.push_back(CH_BSLASH);
                endcase
            end
        endcase
    endfunction

    task automatic report_err(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic send_byte(input logic ls, input logic [7:0] c, input logic [7:0] nx,
                             input logic fixed, input lex_out_t want);
        lex_out_t pred;
        @(negedge i_clk);
        while (gap_now()) begin
            in_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.line_start <= ls;
        in_bus.text_byte  <= c;
        in_bus.next_byte  <= nx;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        pred = classify_byte(ls, c, nx);
        pending_lex_q.push_back(fixed ? want : pred);
        bytes_sent++;
    endtask

    task automatic send_line();
        logic ls;
        logic noise;
        int n;
        text_q.delete();
        noise = ($urandom_range(9) == 0);
        if (noise) begin
            n = $urandom_range(1, 12);
            repeat (n) text_q.push_back(8'($urandom_range(255)));
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) add_token();
        end
        ls = ($urandom_range(9) != 0);
        foreach (text_q[i])
            send_byte(i == 0 ? ls : (noise && $urandom_range(3) == 0), text_q[i],
                      i + 1 < text_q.size() ? text_q[i + 1] : 8'($urandom_range(255)),
                      1'b0, NO_WANT);
        lines_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (pending_lex_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_tab(input logic [TAB_BITS-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tab_cfg = v;
        tab_writes++;
    endtask

    always @(negedge i_clk)
        res_bus.ready <= no_gaps || ($urandom_range(99) >= 7);

    always @(posedge i_clk) begin : result_check
        lex_out_t want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_lex_q.size() == 0) begin
                report_err("result beat with no byte pending");
            end else begin
                want = pending_lex_q.pop_front();
                if (res_bus.color_class !== want.cls)
                    report_err($sformatf("result %0d: class %0d, want %0d",
                                         results_checked, res_bus.color_class, want.cls));
                if (res_bus.draw_glyph !== want.glyph)
                    report_err($sformatf("result %0d: glyph %0b, want %0b",
                                         results_checked, res_bus.draw_glyph, want.glyph));
                if (res_bus.start_column !== want.col)
                    report_err($sformatf("result %0d: column %0d, want %0d",
                                         results_checked, res_bus.start_column, want.col));
                if (res_bus.advance !== want.adv)
                    report_err($sformatf("result %0d: advance %0d, want %0d",
                                         results_checked, res_bus.advance, want.adv));
                results_checked++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d results still pending", pending_lex_q.size());
        $display("** code_syntax_class_lexer: FAILED **");
        $finish;
    end

    initial begin
        logic [TAB_BITS-1:0] tab_plan [6];
        int start;
        tab_plan          = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17};
        err_count         = 0;
        bytes_sent        = 0;
        lines_sent        = 0;
        results_checked   = 0;
        tab_writes        = 0;
        no_gaps           = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        in_bus.valid      = 1'b0;
        in_bus.line_start = 1'b0;
        in_bus.text_byte  = '0;
        in_bus.next_byte  = '0;
        res_bus.ready     = 1'b0;
        clear_line();
        tab_cfg = TAB_SIZE_RST;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].ls, dir_rows[i].c, dir_rows[i].nx,
                      dir_rows[i].fixed, dir_rows[i].want);

        // tab size shrinks below the current phase in mid-line
        drain();
        write_tab(5'd8);
        send_byte(1'b1, "a", "b", 1'b0, NO_WANT);
        send_byte(1'b0, "b", "c", 1'b0, NO_WANT);
        send_byte(1'b0, "c", "d", 1'b0, NO_WANT);
        send_byte(1'b0, "d", "e", 1'b0, NO_WANT);
        send_byte(1'b0, "e", CH_TAB, 1'b0, NO_WANT);
        drain();
        write_tab(5'd2);
        send_byte(1'b0, CH_TAB, "x", 1'b0, NO_WANT);

        // one long line of tabs runs the column into saturation
        drain();
        write_tab(TAB_SIZE_MAX);
        for (int k = 0; k < 4100; k++)
            send_byte(k == 0, CH_TAB, CH_TAB, 1'b0, NO_WANT);
        send_byte(1'b0, "a", "b", 1'b0, NO_WANT);
        send_byte(1'b0, CH_TAB, "c", 1'b0, NO_WANT);
        send_byte(1'b0, "c", 8'h00, 1'b0, NO_WANT);

        foreach (tab_plan[p]) begin
            drain();
            write_tab(tab_plan[p]);
            no_gaps = (p == 2);
            start = bytes_sent;
            while (bytes_sent - start < 135)
                send_line();
        end
        no_gaps = 1'b0;

        drain();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d bytes (%0d random lines), checked %0d results.",
                 bytes_sent, lines_sent, results_checked);
        $display("Covered %0d tab-size writes incl. 0/1/16/17/31 and column saturation.",
                 tab_writes);
        if (err_count == 0) begin
            $display("** code_syntax_class_lexer: PASSED **");
        end else begin
            $display("%0d mismatches", err_count);
            $display("** code_syntax_class_lexer: FAILED **");
        end
        $finish;
    end

endmodule
